// ===== design/rcd_pkg.sv =====
`default_nettype none

package rcd_pkg;

    localparam int MAX_ELEMENTS    = 1024;
    localparam int MAX_BULK_LENGTH = 65535;

    localparam int CAP_MAX = (MAX_ELEMENTS > MAX_BULK_LENGTH) ? MAX_ELEMENTS : MAX_BULK_LENGTH;
    localparam int ACC_W   = $clog2(CAP_MAX + 2);
    localparam int SUM_W   = ACC_W + 4;
    localparam int ELEM_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int PAY_W   = $clog2(MAX_BULK_LENGTH + 1);
    localparam int TOK_W   = 10;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_WORDS     = 2'd1,
        MODE_ARRAY     = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_COUNT    = 3'd0,
        PH_COUNT_LF = 3'd1,
        PH_DOLLAR   = 3'd2,
        PH_LEN      = 3'd3,
        PH_LEN_LF   = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_SKIP     = 3'd6,
        PH_DONE     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_TRUNC  = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       token_byte;
        logic             token_first;
        logic             token_last;
        logic [TOK_W-1:0] token_number;
        logic             message_done;
        logic [1:0]       parse_status;
    } t_out_item;

    // one parsed byte gives one or two results
    typedef struct packed {
        logic      two;
        t_out_item res0;
        t_out_item res1;
    } t_rec;

    function automatic t_out_item mk_res(input logic v, input logic [7:0] b, input logic f,
                                         input logic l, input logic [TOK_W-1:0] n);
        t_out_item r;
        r.byte_valid   = v;
        r.token_byte   = b;
        r.token_first  = f;
        r.token_last   = l;
        r.token_number = n;
        r.message_done = 1'b0;
        r.parse_status = ST_OK;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/resp_command_deframer.sv =====
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+----------------------------
// input     | in        | push / full          | i_in_item   (t_in_item)
// result    | out       | empty / pop          | o_out_item  (t_out_item)
//
// one message byte is taken every cycle while full is low
// a result is written into the queue, then loaded into the unpacker's output register before it shows
// results leave one per cycle while pop is high and empty is low; the last byte of a message may give two
// a four-entry queue between parser and unpacker absorbs result stalls
// reset is synchronous and returns the parser to the start of a message

module resp_command_deframer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  rcd_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  wire                 pop,
    output rcd_pkg::t_out_item  o_out_item
);
    import rcd_pkg::*;

    logic  in_take;
    logic  rec_valid;
    t_rec  rec;
    t_rec  head;
    logic  head_valid;
    logic  head_take;

    assign in_take = push && !full;

    rcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_take),
        .i_item      (i_in_item),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    rcd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (rec_valid),
        .i_wr_rec   (rec),
        .i_rd       (head_take),
        .o_head     (head),
        .o_nonempty (head_valid),
        .o_full     (full)
    );

    rcd_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_take  (head_take),
        .o_item       (o_out_item),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

`default_nettype wire

// ===== design/rcd_parser.sv =====
`default_nettype none

module rcd_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  rcd_pkg::t_in_item   i_item,
    output logic                o_rec_valid,
    output rcd_pkg::t_rec       o_rec
);
    import rcd_pkg::*;

    t_mode              r_mode, n_mode;
    t_phase             r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ELEM_W-1:0]  r_elem, n_elem;
    logic [PAY_W-1:0]   r_pay, n_pay;
    logic [1:0]         r_skip, n_skip;
    logic [TOK_W-1:0]   r_tok, n_tok;
    logic [7:0]         r_held_byte, n_held_byte;
    logic               r_held_valid, n_held_valid;
    logic               r_held_first, n_held_first;
    t_status            r_err, n_err;
    logic               r_digit, n_digit;
    logic               r_sign, n_sign;
    logic               r_neg, n_neg;

    logic [7:0]         c;
    logic               is_space;
    logic               is_digit;
    logic [SUM_W-1:0]   acc_ext;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   cap;
    logic [ACC_W-1:0]   acc_sat;
    logic               m_v, e_v;
    t_out_item          m_res, e_res;
    t_status            status;

    assign c        = i_item.data_byte;
    assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_ext  = SUM_W'(r_acc);
    assign sum      = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(c - CH_ZERO);
    assign cap      = (r_phase == PH_LEN) ? SUM_W'(MAX_BULK_LENGTH) : SUM_W'(MAX_ELEMENTS);
    assign acc_sat  = (sum > cap) ? ACC_W'(cap + SUM_W'(1)) : sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_UNDECIDED;
            r_phase      <= PH_COUNT;
            r_acc        <= '0;
            r_elem       <= '0;
            r_pay        <= '0;
            r_skip       <= '0;
            r_tok        <= '0;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_err        <= ST_OK;
            r_digit      <= 1'b0;
            r_sign       <= 1'b0;
            r_neg        <= 1'b0;
        end else if (i_valid) begin
            r_mode       <= n_mode;
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_elem       <= n_elem;
            r_pay        <= n_pay;
            r_skip       <= n_skip;
            r_tok        <= n_tok;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
            r_err        <= n_err;
            r_digit      <= n_digit;
            r_sign       <= n_sign;
            r_neg        <= n_neg;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_elem       = r_elem;
        n_pay        = r_pay;
        n_skip       = r_skip;
        n_tok        = r_tok;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_err        = r_err;
        n_digit      = r_digit;
        n_sign       = r_sign;
        n_neg        = r_neg;
        m_v          = 1'b0;
        e_v          = 1'b0;
        m_res        = '0;
        e_res        = '0;
        status       = ST_OK;

        if (r_mode == MODE_UNDECIDED && c == CH_STAR) begin
            n_mode  = MODE_ARRAY;
            n_phase = PH_COUNT;
            n_acc   = '0;
            n_digit = 1'b0;
            n_sign  = 1'b0;
            n_neg   = 1'b0;
        end else if (r_mode == MODE_ARRAY) begin
            unique case (r_phase)
                PH_COUNT, PH_LEN: begin
                    if (is_digit) begin
                        n_digit = 1'b1;
                        n_acc   = acc_sat;
                    end else if ((c == CH_PLUS || c == CH_MINUS) && !r_digit && !r_sign) begin
                        n_sign = 1'b1;
                        n_neg  = (c == CH_MINUS);
                    end else if (c == CH_CR && r_digit) begin
                        n_phase = (r_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                    end else begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DONE;
                    end
                end
                PH_COUNT_LF: begin
                    if (c != CH_LF) begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DONE;
                    end else if (r_neg || r_acc == '0) begin
                        n_phase = PH_DONE;
                    end else if (r_acc > ACC_W'(MAX_ELEMENTS)) begin
                        n_err   = ST_RANGE;
                        n_phase = PH_DONE;
                    end else begin
                        n_elem  = r_acc[ELEM_W-1:0];
                        n_phase = PH_DOLLAR;
                    end
                end
                PH_DOLLAR: begin
                    if (c == CH_DOLLAR) begin
                        n_acc   = '0;
                        n_digit = 1'b0;
                        n_sign  = 1'b0;
                        n_neg   = 1'b0;
                        n_phase = PH_LEN;
                    end else begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DONE;
                    end
                end
                PH_LEN_LF: begin
                    if (c != CH_LF) begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DONE;
                    end else if (r_neg && r_acc != '0) begin
                        n_err   = ST_FORMAT;
                        n_phase = PH_DONE;
                    end else if (r_acc > ACC_W'(MAX_BULK_LENGTH)) begin
                        n_err   = ST_RANGE;
                        n_phase = PH_DONE;
                    end else if (r_acc == '0) begin
                        // empty token
                        m_v    = 1'b1;
                        m_res  = mk_res(1'b0, 8'h00, 1'b1, 1'b1, r_tok);
                        n_tok  = r_tok + TOK_W'(1);
                        n_elem = r_elem - ELEM_W'(1);
                        if (r_elem == ELEM_W'(1)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = 2'd2;
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_pay        = r_acc[PAY_W-1:0];
                        n_held_first = 1'b1;
                        n_phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    m_v          = 1'b1;
                    m_res        = mk_res(1'b1, c, r_held_first, r_pay == PAY_W'(1), r_tok);
                    n_held_first = 1'b0;
                    n_pay        = r_pay - PAY_W'(1);
                    if (r_pay == PAY_W'(1)) begin
                        n_tok  = r_tok + TOK_W'(1);
                        n_elem = r_elem - ELEM_W'(1);
                        if (r_elem == ELEM_W'(1)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = 2'd2;
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 2'd1;
                    if (r_skip == 2'd1) begin
                        n_phase = PH_DOLLAR;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end else begin
            n_mode = MODE_WORDS;
            if (!is_space) begin
                if (r_held_valid) begin
                    m_v          = 1'b1;
                    m_res        = mk_res(1'b1, r_held_byte, r_held_first, 1'b0, r_tok);
                    n_held_first = 1'b0;
                end else begin
                    n_held_first = 1'b1;
                end
                n_held_byte  = c;
                n_held_valid = 1'b1;
            end else if (r_held_valid) begin
                m_v          = 1'b1;
                m_res        = mk_res(1'b1, r_held_byte, r_held_first, 1'b1, r_tok);
                n_held_valid = 1'b0;
                n_tok        = r_tok + TOK_W'(1);
            end
        end

        if (i_item.end_of_message) begin
            if (n_mode == MODE_WORDS) begin
                status = ST_OK;
                if (n_held_valid) begin
                    e_v   = 1'b1;
                    e_res = mk_res(1'b1, n_held_byte, n_held_first, 1'b1, n_tok);
                end
            end else begin
                status = (n_phase == PH_DONE) ? n_err : ST_TRUNC;
            end
            if (!m_v && !e_v) begin
                e_v   = 1'b1;
                e_res = '0;
            end
            if (e_v) begin
                e_res.message_done = 1'b1;
                e_res.parse_status = status;
            end else begin
                m_res.message_done = 1'b1;
                m_res.parse_status = status;
            end
            // back to the start of a message
            n_mode       = MODE_UNDECIDED;
            n_phase      = PH_COUNT;
            n_acc        = '0;
            n_elem       = '0;
            n_pay        = '0;
            n_skip       = '0;
            n_tok        = '0;
            n_held_byte  = '0;
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
            n_err        = ST_OK;
            n_digit      = 1'b0;
            n_sign       = 1'b0;
            n_neg        = 1'b0;
        end
    end

    assign o_rec_valid = i_valid && (m_v || e_v);
    assign o_rec.two   = m_v && e_v;
    assign o_rec.res0  = m_v ? m_res : e_res;
    assign o_rec.res1  = e_res;

`ifndef ASSERT_OFF
    a_empty_token_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && !o_rec.res0.byte_valid && !o_rec.res0.message_done
        |-> o_rec.res0.token_first && o_rec.res0.token_last)
        else $error("status-free empty result is not a complete empty token");
    a_two_ends_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && o_rec.two |-> o_rec.res1.message_done && !o_rec.res0.message_done)
        else $error("second result of a byte must close the message");
`endif

endmodule

`default_nettype wire

// ===== design/rcd_fifo.sv =====
`default_nettype none

module rcd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  rcd_pkg::t_rec       i_wr_rec,
    input  wire                 i_rd,
    output rcd_pkg::t_rec       o_head,
    output logic                o_nonempty,
    output logic                o_full
);
    import rcd_pkg::*;

    t_rec                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_comb begin
        n_wr_ptr = i_wr ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_rd ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_cnt    = r_cnt + Q_CNT_W'(i_wr) - Q_CNT_W'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == Q_CNT_W'(Q_DEPTH));

`ifndef ASSERT_OFF
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> r_cnt != '0)
        else $error("queue read while empty");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_cnt == Q_CNT_W'(Q_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

// ===== design/rcd_unpack.sv =====
`default_nettype none

module rcd_unpack (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_head_valid,
    input  rcd_pkg::t_rec       i_head,
    output logic                o_head_take,
    output rcd_pkg::t_out_item  o_item,
    output logic                o_empty,
    input  wire                 i_pop
);
    import rcd_pkg::*;

    t_rec  r_rec;
    logic  r_valid, n_valid;
    logic  r_second, n_second;
    logic  rec_done;

    assign rec_done    = i_pop && r_valid && (!r_rec.two || r_second);
    assign o_head_take = i_head_valid && (!r_valid || rec_done);

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (o_head_take) begin
            n_valid  = 1'b1;
            n_second = 1'b0;
        end else if (rec_done) begin
            n_valid  = 1'b0;
            n_second = 1'b0;
        end else if (i_pop && r_valid) begin
            n_second = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_take) begin
            r_rec <= i_head;
        end
    end

    assign o_item  = r_second ? r_rec.res1 : r_rec.res0;
    assign o_empty = !r_valid;

`ifndef ASSERT_OFF
    a_second_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_valid && r_rec.two)
        else $error("second result shown for a single-result record");
`endif

endmodule

`default_nettype wire

// ===== sim/resp_command_deframer_tb.sv =====
module resp_command_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1550;

    typedef enum logic [1:0] {
        NUM_MORE = 2'd0,
        NUM_END  = 2'd1,
        NUM_BAD  = 2'd2
    } t_num_step;

    class token_scoreboard;
        t_mode             mode;
        t_phase            phase;
        logic [ACC_W-1:0]  acc;
        logic [ELEM_W-1:0] elems_left;
        logic [PAY_W-1:0]  pay_left;
        logic [1:0]        skip_left;
        logic [TOK_W-1:0]  tok_idx;
        logic [7:0]        held_byte;
        logic              held_valid;
        logic              held_first;
        t_status           err;
        logic              digit_seen;
        logic              sign_seen;
        logic              negative;
        t_out_item         step_q[$];
        t_out_item         token_q[$];
        int                mismatches;
        int                noted;
        int                checked;

        function new();
            mismatches = 0;
            noted = 0;
            checked = 0;
            clear_message();
        endfunction

        function void clear_number();
            acc = '0;
            digit_seen = 1'b0;
            sign_seen = 1'b0;
            negative = 1'b0;
        endfunction

        function void clear_message();
            mode = MODE_UNDECIDED;
            phase = PH_COUNT;
            clear_number();
            elems_left = '0;
            pay_left = '0;
            skip_left = '0;
            tok_idx = '0;
            held_byte = '0;
            held_valid = 1'b0;
            held_first = 1'b0;
            err = ST_OK;
        endfunction

        function void emit(logic v, logic [7:0] b, logic f, logic l);
            t_out_item r;
            r.byte_valid = v;
            r.token_byte = b;
            r.token_first = f;
            r.token_last = l;
            r.token_number = tok_idx;
            r.message_done = 1'b0;
            r.parse_status = ST_OK;
            step_q = {step_q, r};
        endfunction

        function void fail(t_status code);
            err = code;
            phase = PH_DONE;
        endfunction

        function t_num_step number_char(logic [7:0] c, logic [SUM_W-1:0] cap);
            logic [SUM_W-1:0] sum;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                digit_seen = 1'b1;
                sum = SUM_W'(acc) * SUM_W'(10) + SUM_W'(c - CH_ZERO);
                if (sum > cap) sum = cap + 1'b1;
                acc = sum[ACC_W-1:0];
                return NUM_MORE;
            end
            if ((c == CH_PLUS || c == CH_MINUS) && !digit_seen && !sign_seen) begin
                sign_seen = 1'b1;
                negative = (c == CH_MINUS);
                return NUM_MORE;
            end
            if (c == CH_CR && digit_seen) return NUM_END;
            return NUM_BAD;
        endfunction

        function void finish_token();
            tok_idx = tok_idx + 1'b1;
            elems_left = elems_left - 1'b1;
            if (elems_left == '0) begin
                phase = PH_DONE;
            end else begin
                skip_left = 2'd2;
                phase = PH_SKIP;
            end
        endfunction

        function void count_done();
            if (negative || acc == '0) begin
                phase = PH_DONE;
            end else if (acc > ACC_W'(MAX_ELEMENTS)) begin
                fail(ST_RANGE);
            end else begin
                elems_left = acc[ELEM_W-1:0];
                phase = PH_DOLLAR;
            end
        endfunction

        function void length_done();
            if (negative && acc != '0) begin
                fail(ST_FORMAT);
            end else if (acc > ACC_W'(MAX_BULK_LENGTH)) begin
                fail(ST_RANGE);
            end else if (acc == '0) begin
                emit(1'b0, 8'h00, 1'b1, 1'b1);
                finish_token();
            end else begin
                pay_left = acc[PAY_W-1:0];
                held_first = 1'b1;
                phase = PH_PAYLOAD;
            end
        endfunction

        function void array_byte(logic [7:0] c);
            t_num_step r;
            case (phase)
                PH_COUNT: begin
                    r = number_char(c, SUM_W'(MAX_ELEMENTS));
                    if (r == NUM_END) phase = PH_COUNT_LF;
                    else if (r == NUM_BAD) fail(ST_FORMAT);
                end
                PH_COUNT_LF: begin
                    if (c == CH_LF) count_done();
                    else fail(ST_FORMAT);
                end
                PH_DOLLAR: begin
                    if (c == CH_DOLLAR) begin
                        clear_number();
                        phase = PH_LEN;
                    end else begin
                        fail(ST_FORMAT);
                    end
                end
                PH_LEN: begin
                    r = number_char(c, SUM_W'(MAX_BULK_LENGTH));
                    if (r == NUM_END) phase = PH_LEN_LF;
                    else if (r == NUM_BAD) fail(ST_FORMAT);
                end
                PH_LEN_LF: begin
                    if (c == CH_LF) length_done();
                    else fail(ST_FORMAT);
                end
                PH_PAYLOAD: begin
                    emit(1'b1, c, held_first, pay_left == PAY_W'(1));
                    held_first = 1'b0;
                    pay_left = pay_left - 1'b1;
                    if (pay_left == '0) finish_token();
                end
                PH_SKIP: begin
                    skip_left = skip_left - 1'b1;
                    if (skip_left == '0) phase = PH_DOLLAR;
                end
                default: begin
                end
            endcase
        endfunction

        function void word_byte(logic [7:0] c);
            logic space;
            space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            if (!space) begin
                if (held_valid) begin
                    emit(1'b1, held_byte, held_first, 1'b0);
                    held_first = 1'b0;
                end else begin
                    held_first = 1'b1;
                end
                held_byte = c;
                held_valid = 1'b1;
            end else if (held_valid) begin
                emit(1'b1, held_byte, held_first, 1'b1);
                held_valid = 1'b0;
                tok_idx = tok_idx + 1'b1;
            end
        endfunction

        function void note_byte(t_in_item it);
            logic [7:0] c;
            logic       eom;
            t_status    status;
            t_out_item  last;
            c = it.data_byte;
            eom = it.end_of_message;
            step_q.delete();
            noted++;
            if (mode == MODE_UNDECIDED) begin
                if (c == CH_STAR) begin
                    mode = MODE_ARRAY;
                    phase = PH_COUNT;
                    clear_number();
                end else begin
                    mode = MODE_WORDS;
                    word_byte(c);
                end
            end else if (mode == MODE_ARRAY) begin
                array_byte(c);
            end else begin
                word_byte(c);
            end
            if (eom) begin
                if (mode == MODE_WORDS) begin
                    if (held_valid) begin
                        emit(1'b1, held_byte, held_first, 1'b1);
                        held_valid = 1'b0;
                    end
                    status = ST_OK;
                end else begin
                    status = (phase == PH_DONE) ? err : ST_TRUNC;
                end
                if (step_q.size() == 0) begin
                    emit(1'b0, 8'h00, 1'b0, 1'b0);
                    last = step_q.pop_back();
                    last.token_number = '0;
                end else begin
                    last = step_q.pop_back();
                end
                last.message_done = 1'b1;
                last.parse_status = status;
                step_q = {step_q, last};
                clear_message();
            end
            foreach (step_q[k]) token_q = {token_q, step_q[k]};
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("ERROR: %s", what);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 checked, name, got, want));
        endtask

        task check_token(t_out_item got);
            t_out_item want;
            if (token_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected: %h", checked, got));
                checked++;
                return;
            end
            want = token_q.pop_front();
            compare_field("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
            compare_field("token_byte", 16'(got.token_byte), 16'(want.token_byte));
            compare_field("token_first", 16'(got.token_first), 16'(want.token_first));
            compare_field("token_last", 16'(got.token_last), 16'(want.token_last));
            compare_field("token_number", 16'(got.token_number), 16'(want.token_number));
            compare_field("message_done", 16'(got.message_done), 16'(want.message_done));
            compare_field("parse_status", 16'(got.parse_status), 16'(want.parse_status));
            checked++;
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    token_scoreboard sb = new();

    logic [7:0] msg_q[$];
    string      crlf = "\015\012";
    int         burst_left = 0;
    int         cycle_count = 0;
    int         pop_run = 0;
    bit         pop_on = 1'b0;
    bit         pop_choppy = 1'b0;

    resp_command_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            if (push && !full) sb.note_byte(i_in_item);
            if (pop && !empty) sb.check_token(o_out_item);
        end
    end

    // receiver: runs of pops and stalls, some runs choppy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop_run == 0) begin
                pop_on = !pop_on;
                pop_run = pop_on ? $urandom_range(1, 40) : $urandom_range(1, 8);
                pop_choppy = pop_on && ($urandom_range(0, 3) == 0);
            end
            pop_run--;
            pop <= pop_on && (!pop_choppy || ($urandom_range(0, 1) == 1));
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        t_in_item it;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        it.data_byte = b;
        it.end_of_message = eom;
        push <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_msg();
        foreach (msg_q[k]) send_byte(msg_q[k], k == msg_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.token_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        msg_q = {msg_q, b};
    endfunction

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endfunction

    function automatic void put_num(input int v);
        put_text($sformatf("%0d", v));
    endfunction

    function automatic void put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 8))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_DOLLAR;
            3: return CH_MINUS;
            4: return CH_PLUS;
            5: return CH_ZERO;
            6: return CH_NINE;
            7: return CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_array_msg();
        int count;
        int shown;
        int len;
        int r;
        int cut;
        msg_q.delete();
        put_byte(CH_STAR);
        r = $urandom_range(0, 99);
        if (r < 6) begin
            put_text("-");
            put_num($urandom_range(0, 5));
            count = 0;
        end else if (r < 10) begin
            put_num(0);
            count = 0;
        end else if (r < 13) begin
            count = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6);
            put_num(count);
        end else begin
            count = $urandom_range(1, 5);
            if (r < 20) put_text("+");
            else if (r < 25) put_text("0");
            put_num(count);
        end
        put_crlf();
        shown = (count > 6) ? $urandom_range(1, 4) : count;
        for (int e = 0; e < shown; e++) begin
            put_byte(CH_DOLLAR);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                put_text("-");
                put_num($urandom_range(0, 3));
                len = 0;
            end else if (r < 8) begin
                put_num($urandom_range(MAX_BULK_LENGTH - 5, MAX_BULK_LENGTH + 5));
                len = $urandom_range(0, 4);
            end else begin
                len = (r < 20) ? $urandom_range(7, 24) : $urandom_range(0, 6);
                put_num(len);
            end
            put_crlf();
            repeat (len) put_byte(8'($urandom_range(0, 255)));
            if (e < shown - 1 || $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 5) != 0) begin
                    put_crlf();
                end else begin
                    put_byte(8'($urandom_range(0, 255)));
                    put_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        r = $urandom_range(0, 99);
        if (r < 15 && msg_q.size() > 1) begin
            msg_q[$urandom_range(1, msg_q.size() - 1)] = pick_special();
        end else if (r < 25) begin
            cut = $urandom_range(1, msg_q.size());
            while (msg_q.size() > cut) void'(msg_q.pop_back());
        end else if (r < 33) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_word_msg();
        int r;
        int sel;
        msg_q.delete();
        repeat ($urandom_range(1, 24)) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                put_byte(8'("a" + $urandom_range(0, 25)));
            end else if (r < 65) begin
                sel = $urandom_range(0, 5);
                put_byte((sel == 5) ? CH_SPACE : 8'(CH_TAB + sel));
            end else begin
                put_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic void build_noise_msg();
        msg_q.delete();
        put_byte(($urandom_range(0, 1) == 1) ? CH_STAR : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 7)) put_byte(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        int r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text({"*2", crlf, "$3", crlf, "SET", crlf, "$0", crlf, crlf});
        send_text({"*-1", crlf});
        send_text({"*-0", crlf});
        send_text({"*1025", crlf});
        send_text({"*1024", crlf, "$1", crlf, "a"});
        send_text({"*1", crlf, "$-2", crlf});
        send_text({"*1", crlf, "$-0", crlf});
        send_text({"*1", crlf, "$65536", crlf});
        send_text({"*1", crlf, "$65535", crlf, "ab"});
        send_text({"*1", crlf, "$99999999999", crlf});
        send_text({"*1", crlf, "x"});
        send_text({"*+", crlf});
        send_text({"*1", "\015", "x"});
        send_text({"*1-", crlf});
        send_text({"*2", crlf, "$1", crlf, "a", crlf, "$2", crlf, "bc"});
        send_text({"*1", crlf, "$1", crlf, "z", crlf, "tail"});
        send_text({"*2", crlf, "$1", crlf, "a", crlf});
        send_text("*");
        send_text(" get  key\tval ");
        send_text("a");
        send_text(" ");
        msg_q = '{8'h00, 8'hFF, CH_SPACE, 8'h7F};
        send_msg();

        // hold off until every queued result has been seen
        wait_drained();

        while (sb.noted < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 65) build_array_msg();
            else if (r < 88) build_word_msg();
            else build_noise_msg();
            send_msg();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rcd_pkg.sv
design/rcd_parser.sv
design/rcd_fifo.sv
design/rcd_unpack.sv
design/resp_command_deframer.sv
sim/resp_command_deframer_tb.sv
